FILE: rtl/pwmt_pkg.sv
package pwmt_pkg;

  localparam int NUM_CHANNELS_DEF = 4;
  localparam int COUNT_WIDTH_DEF  = 16;
  localparam int MAX_CHANNELS     = 4;
  localparam int DUTY_W           = 16;
  localparam int RES_W            = 5;
  localparam int PRESC_W          = 16;
  localparam int ADDR_W           = 3;
  localparam int APB_DATA_W       = 32;

  localparam logic [RES_W-1:0]   RES_RESET   = 5'd16;
  localparam logic [RES_W-1:0]   RES_MAX     = 5'd16;
  localparam logic [RES_W-1:0]   RES_MIN     = 5'd1;
  localparam logic [PRESC_W-1:0] PRESC_RESET = 16'd0;

  localparam logic REG_RESOLUTION = 1'b0;
  localparam logic REG_PRESCALER  = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_DUTY    = 2'd1,
    OP_ENABLE  = 2'd2,
    OP_DISABLE = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [RES_W-1:0]   resolution_bits;
    logic [PRESC_W-1:0] prescaler;
  } cfg_t;

  typedef struct packed {
    logic [MAX_CHANNELS-1:0] pwm_levels;
    logic [15:0]             count_now;
    logic                    update_event;
  } result_t;

endpackage

FILE: rtl/four_channel_pwm_timer.sv
// Each result is registered in the output stage before it appears on out_.
// Throughput: one request per cycle while in_tready is high; state and result
// come from one pass of logic between the timer registers and a two-entry
// output stage. in_tready drops only while both entries hold results.
// Reset: synchronous, active low; counters, compares and enables clear,
// resolution returns to 16 and prescaler to 0.
module four_channel_pwm_timer #(
  parameter int NUM_CHANNELS = pwmt_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_WIDTH  = pwmt_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,   // duty[15:0]
  input  logic [3:0]                        in_tuser,   // opcode[1:0], channel[3:2]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [23:0]                       out_tdata,  // pwm_levels[3:0], count_now[19:4]
  output logic [0:0]                        out_tuser,  // update_event[0]
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [pwmt_pkg::ADDR_W-1:0]       cfg_paddr,
  input  logic [pwmt_pkg::APB_DATA_W-1:0]   cfg_pwdata,
  output logic [pwmt_pkg::APB_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  pwmt_pkg::cfg_t    cfg_r, cfg_nxt;
  pwmt_pkg::result_t core_result;
  pwmt_pkg::result_t out_result;
  logic              cfg_wr;
  logic              in_accept;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        pwmt_pkg::REG_RESOLUTION:
          cfg_nxt.resolution_bits = cfg_pwdata[pwmt_pkg::RES_W-1:0];
        pwmt_pkg::REG_PRESCALER:
          cfg_nxt.prescaler = cfg_pwdata[pwmt_pkg::PRESC_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      pwmt_pkg::REG_RESOLUTION:
        cfg_prdata = pwmt_pkg::APB_DATA_W'(cfg_r.resolution_bits);
      pwmt_pkg::REG_PRESCALER:
        cfg_prdata = pwmt_pkg::APB_DATA_W'(cfg_r.prescaler);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.resolution_bits <= pwmt_pkg::RES_RESET;
      cfg_r.prescaler       <= pwmt_pkg::PRESC_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_accept = in_tvalid && in_tready;

  pwmt_core #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .opcode    (pwmt_pkg::opcode_t'(in_tuser[1:0])),
    .channel   (in_tuser[3:2]),
    .duty      (in_tdata),
    .cfg       (cfg_r),
    .result    (core_result)
  );

  pwmt_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (core_result),
    .ready     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_result)
  );

  assign out_tdata = {4'b0000, out_result.count_now, out_result.pwm_levels};
  assign out_tuser = out_result.update_event;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending right after reset");

  a_wrap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[19:4] == 16'd0)
    else $error("update event with nonzero counter");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && $past(out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

endmodule

FILE: rtl/pwmt_core.sv
module pwmt_core #(
  parameter int NUM_CHANNELS = pwmt_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_WIDTH  = pwmt_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_accept,
  input  pwmt_pkg::opcode_t             opcode,
  input  logic [1:0]                    channel,
  input  logic [pwmt_pkg::DUTY_W-1:0]   duty,
  input  pwmt_pkg::cfg_t                cfg,
  output pwmt_pkg::result_t             result
);

  localparam logic [15:0] CNT_MASK = 16'((17'd1 << COUNT_WIDTH) - 17'd1);

  logic [pwmt_pkg::PRESC_W-1:0] prescale_r, prescale_nxt;
  logic [COUNT_WIDTH-1:0]       count_r, count_nxt;
  logic [COUNT_WIDTH-1:0]       preload_r [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]       preload_nxt [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]       active_r [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]       active_nxt [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]      enable_r, enable_nxt;

  logic [pwmt_pkg::RES_W-1:0] eff_res;
  logic [3:0]                 shift_amt;
  logic [15:0]                period;
  logic [COUNT_WIDTH-1:0]     preload_val;
  logic                       update;
  logic [pwmt_pkg::MAX_CHANNELS-1:0] levels;

  always_comb begin
    if (cfg.resolution_bits < pwmt_pkg::RES_MIN) begin
      eff_res = pwmt_pkg::RES_MIN;
    end else if (cfg.resolution_bits > pwmt_pkg::RES_MAX) begin
      eff_res = pwmt_pkg::RES_MAX;
    end else begin
      eff_res = cfg.resolution_bits;
    end
    shift_amt   = 4'(pwmt_pkg::RES_MAX - eff_res);
    period      = (16'hffff >> shift_amt) & CNT_MASK;
    preload_val = COUNT_WIDTH'(duty >> shift_amt);
  end

  always_comb begin
    prescale_nxt = prescale_r;
    count_nxt    = count_r;
    preload_nxt  = preload_r;
    active_nxt   = active_r;
    enable_nxt   = enable_r;
    update       = 1'b0;
    if (in_accept) begin
      unique case (opcode)
        pwmt_pkg::OP_TICK: begin
          if (prescale_r >= cfg.prescaler) begin
            prescale_nxt = '0;
            if (16'(count_r) >= period) begin
              count_nxt  = '0;
              update     = 1'b1;
              active_nxt = preload_r;
            end else begin
              count_nxt = count_r + COUNT_WIDTH'(1);
            end
          end else begin
            prescale_nxt = prescale_r + pwmt_pkg::PRESC_W'(1);
          end
        end
        pwmt_pkg::OP_DUTY: begin
          for (int n = 0; n < NUM_CHANNELS; n++) begin
            if (channel == 2'(n)) preload_nxt[n] = preload_val;
          end
        end
        pwmt_pkg::OP_ENABLE: begin
          for (int n = 0; n < NUM_CHANNELS; n++) begin
            if (channel == 2'(n)) enable_nxt[n] = 1'b1;
          end
        end
        pwmt_pkg::OP_DISABLE: begin
          for (int n = 0; n < NUM_CHANNELS; n++) begin
            if (channel == 2'(n)) enable_nxt[n] = 1'b0;
          end
        end
      endcase
    end
  end

  always_comb begin
    levels = '0;
    for (int n = 0; n < NUM_CHANNELS; n++) begin
      levels[n] = enable_nxt[n] && (count_nxt < active_nxt[n]);
    end
    result.pwm_levels   = levels;
    result.count_now    = 16'(count_nxt);
    result.update_event = update;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= '0;
      count_r    <= '0;
      enable_r   <= '0;
      for (int n = 0; n < NUM_CHANNELS; n++) begin
        preload_r[n] <= '0;
        active_r[n]  <= '0;
      end
    end else begin
      prescale_r <= prescale_nxt;
      count_r    <= count_nxt;
      enable_r   <= enable_nxt;
      preload_r  <= preload_nxt;
      active_r   <= active_nxt;
    end
  end

endmodule

FILE: rtl/pwmt_obuf.sv
module pwmt_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pwmt_pkg::result_t push_data,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_ready,
  output pwmt_pkg::result_t out_data
);

  logic              main_valid_r, main_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  pwmt_pkg::result_t main_data_r, main_data_nxt;
  pwmt_pkg::result_t skid_data_r, skid_data_nxt;

  assign ready     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_data_nxt  = main_data_r;
    skid_data_nxt  = skid_data_r;
    if (main_valid_r && !out_ready) begin
      if (push) begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = push_data;
      end
    end else if (skid_valid_r) begin
      main_valid_nxt = 1'b1;
      main_data_nxt  = skid_data_r;
      skid_valid_nxt = 1'b0;
    end else begin
      main_valid_nxt = push;
      main_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule
